/* sv/bcomp_pkg.sv */
// Shared types and constants for the barometer compensation core.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bcomp_pkg;

    // Field widths
    localparam int RAW_W     = 24;   // raw converter readings D1, D2
    localparam int COEF_W    = 16;   // calibration words C1..C6
    localparam int TEMP_W    = 19;   // output temperature, 0.01 C
    localparam int PRES_W    = 32;   // output pressure, 0.01 mbar
    localparam int IN_DATA_W  = 48;  // two packed raw readings
    localparam int OUT_DATA_W = 56;  // temp + pressure, padded to bytes
    localparam int OUT_USED_W = TEMP_W + PRES_W;

    // Internal widths
    localparam int DT_W    = 25;     // temperature difference, signed
    localparam int PROD_W  = 42;     // dT times a calibration word, signed
    localparam int DTSQ_W  = 50;     // dT squared, signed container
    localparam int T1_W    = 20;     // first-order temperature, signed
    localparam int OFF1_W  = 36;     // first-order offset / sensitivity
    localparam int T2_W    = 18;     // second-order temperature term
    localparam int DEV_W   = 21;     // temperature deviation from a threshold
    localparam int SQ_W    = 36;     // squared deviation
    localparam int ACC_W   = 42;     // corrected offset / sensitivity
    localparam int SPLIT_W = 21;     // half of the sensitivity for the split multiply
    localparam int PPLO_W  = RAW_W + SPLIT_W;
    localparam int PPHI_W  = RAW_W + SPLIT_W + 1;
    localparam int SUM_W   = 48;

    // Shift amounts of the compensation formula
    localparam int SH_TEMP = 23;
    localparam int SH_T2   = 31;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_MUL  = 21;
    localparam int SH_PRES = 15;

    // Temperature thresholds in 0.01 C
    localparam logic signed [T1_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [T1_W-1:0] TEMP_COLD = -20'sd1500;

    // Decoupling queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } cfg_idx_t;

    // Calibration words as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } bcomp_coef_t;

    // First-order result handed from the front to the back
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [T1_W-1:0]   temp1;
        logic signed [OFF1_W-1:0] off1;
        logic signed [OFF1_W-1:0] sens1;
        logic [T2_W-1:0]          t2;
        logic                     cold;
        logic                     very_cold;
    } bcomp_item_t;

endpackage

`default_nettype wire

/* sv/bcomp_front.sv */
// Front half: accepts raw reading pairs, computes dT and the first-order terms.
// Classifies each item as cold / very cold. Depends on bcomp_pkg.
`default_nettype none

module bcomp_front
    import bcomp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bcomp_coef_t           coef,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bcomp_item_t                out_item
);

    // Stage valids
    logic f0_v_reg, f1_v_reg, f2_v_reg;
    logic f0_load, f1_load, f2_load;

    // Stage 0 payload
    logic [RAW_W-1:0]       f0_d1_reg;
    logic signed [DT_W-1:0] f0_dt_reg;
    logic signed [DT_W-1:0] dt_next;

    // Stage 1 payload
    logic [RAW_W-1:0]          f1_d1_reg;
    logic signed [PROD_W-1:0]  prod_t_reg, prod_o_reg, prod_s_reg;
    logic signed [DTSQ_W-1:0]  dtsq_reg;
    logic signed [PROD_W-1:0]  prod_t_next, prod_o_next, prod_s_next;
    logic signed [DTSQ_W-1:0]  dtsq_next;

    // Stage 2 payload
    bcomp_item_t              item_reg;
    bcomp_item_t              item_next;
    logic signed [T1_W-1:0]   temp1_next;

    // Advance each stage when it is empty or its successor takes its item
    assign f2_load  = !f2_v_reg || out_ready;
    assign f1_load  = !f1_v_reg || f2_load;
    assign f0_load  = !f0_v_reg || f1_load;
    assign in_ready = f0_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else
        begin
            if (f0_load)
            begin
                f0_v_reg <= in_valid;
            end
            if (f1_load)
            begin
                f1_v_reg <= f0_v_reg;
            end
            if (f2_load)
            begin
                f2_v_reg <= f1_v_reg;
            end
        end
    end

    // Temperature difference dT = D2 - C5 * 2^8
    assign dt_next = $signed({1'b0, in_data[2*RAW_W-1:RAW_W]})
                   - $signed({1'b0, coef.c5, 8'b0});

    // Products of dT with C6, C4, C3 and with itself
    assign prod_t_next = PROD_W'(f0_dt_reg) * PROD_W'($signed({1'b0, coef.c6}));
    assign prod_o_next = PROD_W'(f0_dt_reg) * PROD_W'($signed({1'b0, coef.c4}));
    assign prod_s_next = PROD_W'(f0_dt_reg) * PROD_W'($signed({1'b0, coef.c3}));
    assign dtsq_next   = DTSQ_W'(f0_dt_reg) * DTSQ_W'(f0_dt_reg);

    // First-order temperature, offset, sensitivity, T2 term and classification
    always_comb
    begin
        temp1_next = {prod_t_reg[PROD_W-1], prod_t_reg[PROD_W-1:SH_TEMP]} + TEMP_REF;
        item_next.d1    = f1_d1_reg;
        item_next.temp1 = temp1_next;
        item_next.off1  = $signed({4'b0, coef.c2, {SH_C2{1'b0}}})
                        + $signed({prod_o_reg[PROD_W-1], prod_o_reg[PROD_W-1:SH_OFF]});
        item_next.sens1 = $signed({5'b0, coef.c1, {SH_C1{1'b0}}})
                        + $signed({{2{prod_s_reg[PROD_W-1]}}, prod_s_reg[PROD_W-1:SH_SENS]});
        item_next.t2        = dtsq_reg[SH_T2+T2_W-1:SH_T2];
        item_next.cold      = (temp1_next < TEMP_REF);
        item_next.very_cold = (temp1_next < TEMP_COLD);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (f0_load)
        begin
            f0_d1_reg <= in_data[RAW_W-1:0];
            f0_dt_reg <= dt_next;
        end
        if (f1_load)
        begin
            f1_d1_reg  <= f0_d1_reg;
            prod_t_reg <= prod_t_next;
            prod_o_reg <= prod_o_next;
            prod_s_reg <= prod_s_next;
            dtsq_reg   <= dtsq_next;
        end
        if (f2_load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = f2_v_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

/* sv/bcomp_queue.sv */
// Short queue between the front and the back half, so each can stall alone.
// Depends on bcomp_pkg (item type and depth).
`default_nettype none

module bcomp_queue
    import bcomp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire bcomp_item_t  wr_item,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output bcomp_item_t       rd_item
);

    bcomp_item_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push, pop, full;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && rd_ready;
    // A full queue still takes a request in the cycle it hands one on
    assign wr_ready = !full || rd_ready;
    assign push     = wr_valid && wr_ready;
    assign rd_item  = slot_reg[rptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store incoming requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* sv/bcomp_back.sv */
// Back half: second-order corrections and the final pressure computation.
// Holds the output register. Depends on bcomp_pkg.
`default_nettype none

module bcomp_back
    import bcomp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire bcomp_item_t            in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OUT_DATA_W-1:0]       out_data
);

    logic b0_v_reg, b1_v_reg, b2_v_reg, b3_v_reg;
    logic b0_load, b1_load, b2_load, b3_load;

    // Stage 0: squared deviations from both thresholds
    logic signed [DEV_W-1:0]   dev_a, dev_b;
    logic signed [2*DEV_W-1:0] prod_a, prod_b;
    logic [SQ_W-1:0]           sqa_reg, sqb_reg;
    logic [RAW_W-1:0]          b0_d1_reg;
    logic signed [T1_W-1:0]    b0_temp_reg;
    logic signed [OFF1_W-1:0]  b0_off_reg, b0_sens_reg;
    logic [T2_W-1:0]           b0_t2_reg;

    // Stage 1: corrected temperature, offset and sensitivity
    logic [ACC_W-1:0]          five_a, seven_b, eleven_b, off2, sens2;
    logic signed [DEV_W-1:0]   temp2_next;
    logic signed [ACC_W-1:0]   off_next, sens_next;
    logic [RAW_W-1:0]          b1_d1_reg;
    logic [TEMP_W-1:0]         b1_temp_reg;
    logic signed [ACC_W-1:0]   b1_off_reg, b1_sens_reg;

    // Stage 2: split product D1 * SENS
    logic [PPLO_W-1:0]         pplo_reg, pplo_next;
    logic signed [PPHI_W-1:0]  pphi_reg, pphi_next;
    logic [TEMP_W-1:0]         b2_temp_reg;
    logic signed [ACC_W-1:0]   b2_off_reg;

    // Stage 3: output register
    logic signed [SUM_W-1:0]   scaled, diff;
    logic [PRES_W-1:0]         pres_reg;
    logic [TEMP_W-1:0]         b3_temp_reg;

    // Advance each stage when it is empty or its successor takes its item
    assign b3_load  = !b3_v_reg || out_ready;
    assign b2_load  = !b2_v_reg || b3_load;
    assign b1_load  = !b1_v_reg || b2_load;
    assign b0_load  = !b0_v_reg || b1_load;
    assign in_ready = b0_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg <= 1'b0;
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
        end
        else
        begin
            if (b0_load)
            begin
                b0_v_reg <= in_valid;
            end
            if (b1_load)
            begin
                b1_v_reg <= b0_v_reg;
            end
            if (b2_load)
            begin
                b2_v_reg <= b1_v_reg;
            end
            if (b3_load)
            begin
                b3_v_reg <= b2_v_reg;
            end
        end
    end

    // Deviations below 20.00 C and below -15.00 C, squared
    assign dev_a  = {in_item.temp1[T1_W-1], in_item.temp1} - {TEMP_REF[T1_W-1], TEMP_REF};
    assign dev_b  = {in_item.temp1[T1_W-1], in_item.temp1} - {TEMP_COLD[T1_W-1], TEMP_COLD};
    assign prod_a = $signed({{DEV_W{dev_a[DEV_W-1]}}, dev_a})
                  * $signed({{DEV_W{dev_a[DEV_W-1]}}, dev_a});
    assign prod_b = $signed({{DEV_W{dev_b[DEV_W-1]}}, dev_b})
                  * $signed({{DEV_W{dev_b[DEV_W-1]}}, dev_b});

    // Second-order terms by shift and add; zero squares drop the corrections
    always_comb
    begin
        five_a   = ACC_W'({sqa_reg, 2'b0}) + ACC_W'(sqa_reg);
        seven_b  = ACC_W'({sqb_reg, 3'b0}) - ACC_W'(sqb_reg);
        eleven_b = ACC_W'({sqb_reg, 3'b0}) + ACC_W'({sqb_reg, 1'b0}) + ACC_W'(sqb_reg);
        off2     = (five_a >> 1) + seven_b;
        sens2    = (five_a >> 2) + (eleven_b >> 1);
        temp2_next = {b0_temp_reg[T1_W-1], b0_temp_reg} - $signed({3'b0, b0_t2_reg});
        off_next   = $signed({{(ACC_W-OFF1_W){b0_off_reg[OFF1_W-1]}}, b0_off_reg})
                   - $signed(off2);
        sens_next  = $signed({{(ACC_W-OFF1_W){b0_sens_reg[OFF1_W-1]}}, b0_sens_reg})
                   - $signed(sens2);
    end

    // Split multiply: low half unsigned, high half signed
    assign pplo_next = PPLO_W'(b1_d1_reg) * PPLO_W'(b1_sens_reg[SPLIT_W-1:0]);
    assign pphi_next = PPHI_W'($signed({1'b0, b1_d1_reg}))
                     * PPHI_W'($signed(b1_sens_reg[ACC_W-1:SPLIT_W]));

    // Floor of the product over 2^21, minus offset; the high partial is exact
    assign scaled = $signed({{(SUM_W-PPHI_W){pphi_reg[PPHI_W-1]}}, pphi_reg})
                  + $signed(SUM_W'(pplo_reg[PPLO_W-1:SH_MUL]));
    assign diff   = scaled - $signed({{(SUM_W-ACC_W){b2_off_reg[ACC_W-1]}}, b2_off_reg});

    always_ff @(posedge clk)
    begin
        if (b0_load)
        begin
            sqa_reg     <= in_item.cold ? prod_a[SQ_W-1:0] : '0;
            sqb_reg     <= in_item.very_cold ? prod_b[SQ_W-1:0] : '0;
            b0_d1_reg   <= in_item.d1;
            b0_temp_reg <= in_item.temp1;
            b0_off_reg  <= in_item.off1;
            b0_sens_reg <= in_item.sens1;
            b0_t2_reg   <= in_item.cold ? in_item.t2 : '0;
        end
        if (b1_load)
        begin
            b1_d1_reg   <= b0_d1_reg;
            b1_temp_reg <= temp2_next[TEMP_W-1:0];
            b1_off_reg  <= off_next;
            b1_sens_reg <= sens_next;
        end
        if (b2_load)
        begin
            pplo_reg    <= pplo_next;
            pphi_reg    <= pphi_next;
            b2_temp_reg <= b1_temp_reg;
            b2_off_reg  <= b1_off_reg;
        end
        if (b3_load)
        begin
            pres_reg    <= diff[SH_PRES+PRES_W-1:SH_PRES];
            b3_temp_reg <= b2_temp_reg;
        end
    end

    assign out_valid = b3_v_reg;
    assign out_data  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, pres_reg, b3_temp_reg};

endmodule

`default_nettype wire

/* sv/barometer_compensation_core.sv */
// Top level of the barometer compensation core: calibration registers,
// front half, queue and back half. Depends on bcomp_pkg and the bcomp_* modules.
//
// Channel   Dir  Payload (lowest bit first)                 Handshake
// cfg       in   cfg_addr index, cfg_wdata 16-bit word      cfg_we
// s_axis    in   raw_pressure[23:0], raw_temperature[47:24] tvalid/tready
// m_axis    out  temp_centi[18:0], pressure_centi[50:19]    tvalid/tready
//
// Takes one request per cycle unless the output stalls; a result passes through
// 3 front stages, the queue and 4 back stages; the last is the output register.
// The widest multiply is dT squared (25x25); D1 * SENS is cut into two partials.
// Reset clears all valids and calibration words; no clearing pass is needed.
// A stalled output fills the back stages, then the 4-entry queue, then the front.
`default_nettype none

module barometer_compensation_core
    import bcomp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [COEF_W-1:0]      cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // raw_pressure[23:0], raw_temperature[47:24]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // temp_centi[18:0], pressure_centi[50:19], zero pad[55:51]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

    bcomp_coef_t coef_reg;
    bcomp_item_t front_item, queue_item;
    logic        front_valid, front_ready, queue_valid, queue_ready;

    // Calibration register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_C1:  coef_reg.c1 <= cfg_wdata;
                REG_C2:  coef_reg.c2 <= cfg_wdata;
                REG_C3:  coef_reg.c3 <= cfg_wdata;
                REG_C4:  coef_reg.c4 <= cfg_wdata;
                REG_C5:  coef_reg.c5 <= cfg_wdata;
                REG_C6:  coef_reg.c6 <= cfg_wdata;
                default: coef_reg <= coef_reg;
            endcase
        end
    end

    bcomp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    bcomp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    bcomp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_item   (queue_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* sv/bcomp_checker.sv */
// Port-level checks for the barometer compensation core, bound to the top level.
// Depends on bcomp_pkg for widths.
`default_nettype none

module bcomp_checker
    import bcomp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // No result may be pending once reset has been seen
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // A draining output never blocks the input side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // Padding bits above the pressure stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0))
        else $error("nonzero padding in result");

    // An emptied core takes a request right after reset
    a_in_ready_reset: assert property (@(posedge clk)
        !rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind barometer_compensation_core bcomp_checker u_bcomp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
